[hw/rtl/cca_pkg.sv]
// Shared types and constants for the cluster chain allocator.
`timescale 1ns / 1ps
package cca_pkg;

   localparam int ADDR_BITS_DEFAULT = 4;
   localparam int DIV_BITS = 24;
   localparam int CSIZE_BITS = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [CSIZE_BITS-1:0] CLUSTER_BYTES_RESET = 16'd1024;

   localparam logic [2:0] OP_ALLOC  = 3'd0;
   localparam logic [2:0] OP_APPEND = 3'd1;
   localparam logic [2:0] OP_LIST   = 3'd2;
   localparam logic [2:0] OP_SEEK   = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_BAD_START = 2'd2;
   localparam logic [1:0] ST_PAST_END  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_ALLOC, S_JOIN, S_TERM, S_WALK, S_LIST,
      S_SEEK, S_CYC, S_CYCDIV, S_REM, S_DEL
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  start_cluster;
      logic [23:0] byte_count;
      logic [23:0] byte_offset;
   } req_beat_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] cluster;
      logic       entry_used;
      logic [3:0] entry_next;
      logic       entry_next_end;
      logic       last;
   } rsp_beat_type;

endpackage

[hw/rtl/cca_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cca_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [cca_pkg::DIV_BITS-1:0]   dividend,
   input  logic [cca_pkg::CSIZE_BITS-1:0] divisor,
   output logic                           done,
   output logic [cca_pkg::DIV_BITS-1:0]   quotient,
   output logic [cca_pkg::CSIZE_BITS-1:0] remainder
);
   import cca_pkg::*;

   localparam int CNT_W = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0]   quo_ff, quo_in;
   logic [CSIZE_BITS-1:0] rem_ff, rem_in;
   logic [CSIZE_BITS-1:0] dvsr_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CSIZE_BITS:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_BITS-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(DIV_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = CSIZE_BITS'(trial - {1'b0, dvsr_ff});
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[CSIZE_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (go) begin
         dvsr_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[hw/rtl/cluster_chain_allocator.sv]
// Top level of the cluster chain allocator: table, sequencer and result register.
//
// A request beat is taken when start is high and busy is low; busy then stays
// high until the request is finished, but requests answered straight from idle
// (read entry, rejected start clusters, zero-byte allocate or append) never raise
// it. Each result beat appears on rsp_data for one cycle with rsp_strobe high;
// the receiver cannot stall it. Chain list gives one beat per cycle for each chain
// member, up to the smaller of 2^ADDR_BITS and MAX_RESULTS, the last one flagged
// by last. Every other request gives one beat; unknown request codes give none.
// Request time is set by the shared divider, used for length and offset division,
// and by the single table read port, which follows one link or tests one cluster
// a cycle. The cluster size register is written through csr_we and csr_wdata; the
// user must write it only while the block is idle, as the block does not enforce
// this. Reset marks every cluster free with an end link, sets the cluster size to
// 1024 bytes and clears busy and rsp_strobe at the clock edge that samples reset.
`timescale 1ns / 1ps
module cluster_chain_allocator #(
   parameter int ADDR_BITS = cca_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  cca_pkg::req_beat_type          req_data,
   output logic                           rsp_strobe,
   output cca_pkg::rsp_beat_type          rsp_data,
   input  logic                           csr_we,
   input  logic [cca_pkg::CSIZE_BITS-1:0] csr_wdata
);
   import cca_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int CW = AW + 1;
   localparam int NCL = 1 << AW;
   localparam int LIST_CAP = (NCL < MAX_RESULTS) ? NCL : MAX_RESULTS;
   localparam logic [AW:0] END_LINK = (AW + 1)'(NCL);

   state_type state_ff, state_in;

   logic                  used_ff [NCL];
   logic [AW:0]           next_ff [NCL];
   logic [NCL-1:0]        used_vec;
   logic [CSIZE_BITS-1:0] cluster_bytes_ff;
   logic [CSIZE_BITS-1:0] csize;

   logic [2:0]            op_ff, op_in;
   logic [3:0]            start_ff, start_in;
   logic [23:0]           arg_ff, arg_in;
   logic [23:0]           steps_ff, steps_in;
   logic [AW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         prev_ff, prev_in;
   logic [AW-1:0]         first_ff, first_in;
   logic                  have_prev_ff, have_prev_in;
   logic [CW-1:0]         taken_ff, taken_in;
   logic [CW-1:0]         need_ff, need_in;
   logic [AW-1:0]         anchor_ff, anchor_in;
   logic [CW-1:0]         len_ff, len_in;

   logic                  rsp_strobe_ff;
   rsp_beat_type          rsp_data_ff, rsp_beat;
   logic                  emit;

   logic                  accept;
   logic [AW-1:0]         start_idx;
   logic                  in_range;
   logic                  start_ok;
   logic [AW-1:0]         rd_addr;
   logic                  rd_used;
   logic [AW:0]           rd_link;
   logic                  rd_end;
   logic [CW-1:0]         free_cnt;
   logic [24:0]           need_full;
   logic                  short;
   logic                  list_last;
   logic                  take;

   logic                  u_we, u_val, n_we;
   logic [AW-1:0]         u_addr, n_addr;
   logic [AW:0]           n_val;

   logic                  div_go, div_done;
   logic [DIV_BITS-1:0]   div_dividend, div_quo;
   logic [CSIZE_BITS-1:0] div_divisor, div_rem;

   cca_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      for (int i = 0; i < NCL; i++) begin
         used_vec[i] = used_ff[i];
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csize     = (cluster_bytes_ff == '0) ? CSIZE_BITS'(1) : cluster_bytes_ff;
   assign start_idx = AW'(req_data.start_cluster);
   assign in_range  = ({3'b000, req_data.start_cluster} < 7'(NCL));
   assign rd_addr   = (state_ff == S_IDLE) ? start_idx :
                      (state_ff == S_ALLOC) ? idx_ff : cur_ff;
   assign rd_used   = used_ff[rd_addr];
   assign rd_link   = next_ff[rd_addr];
   assign rd_end    = rd_link[AW];
   assign start_ok  = in_range && rd_used;
   assign free_cnt  = CW'(NCL - $countones(used_vec));
   assign need_full = 25'(div_quo) + 25'(div_rem != '0);
   assign short     = need_full > 25'(free_cnt);
   assign list_last = rd_end || ((int'(cnt_ff) + 1) >= LIST_CAP);
   assign take      = !rd_used && (taken_ff + 1'b1 == need_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  OP_ALLOC:  if (req_data.byte_count != '0) state_in = S_DIV;
                  OP_APPEND: if (start_ok && req_data.byte_count != '0) state_in = S_WALK;
                  OP_LIST:   if (start_ok) state_in = S_LIST;
                  OP_SEEK:   if (start_ok) state_in = S_DIV;
                  OP_DELETE: if (start_ok) state_in = S_DEL;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (op_ff == OP_SEEK) state_in = S_SEEK;
               else if (short) state_in = S_IDLE;
               else state_in = S_ALLOC;
            end
         end
         S_ALLOC:  if (take) state_in = (op_ff == OP_APPEND) ? S_JOIN : S_TERM;
         S_JOIN:   state_in = S_TERM;
         S_TERM:   state_in = S_IDLE;
         S_WALK: begin
            if (rd_end) state_in = S_DIV;
            else if (cnt_ff == CW'(NCL)) state_in = S_IDLE;
         end
         S_LIST:   if (list_last) state_in = S_IDLE;
         S_SEEK: begin
            if (24'(cnt_ff) == steps_ff) state_in = S_IDLE;
            else if (cnt_ff == CW'(NCL)) state_in = S_CYC;
            else if (rd_end) state_in = S_IDLE;
         end
         S_CYC:    if (rd_link == {1'b0, anchor_ff}) state_in = S_CYCDIV;
         S_CYCDIV: if (div_done) state_in = S_REM;
         S_REM:    if (cnt_ff == '0) state_in = S_IDLE;
         S_DEL:    if (rd_end || (cnt_ff + 1'b1 == CW'(NCL))) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      start_in     = start_ff;
      arg_in       = arg_ff;
      steps_in     = steps_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      have_prev_in = have_prev_ff;
      taken_in     = taken_ff;
      need_in      = need_ff;
      anchor_in    = anchor_ff;
      len_in       = len_ff;
      u_we         = 1'b0;
      u_addr       = cur_ff;
      u_val        = 1'b0;
      n_we         = 1'b0;
      n_addr       = cur_ff;
      n_val        = END_LINK;
      div_go       = 1'b0;
      div_dividend = arg_ff;
      div_divisor  = csize;
      emit         = 1'b0;
      rsp_beat     = '0;
      rsp_beat.status = ST_OK;
      rsp_beat.last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_data.req_type;
               start_in = req_data.start_cluster;
               arg_in   = (req_data.req_type == OP_SEEK) ? req_data.byte_offset
                                                         : req_data.byte_count;
               cur_in   = start_idx;
               cnt_in   = '0;
               case (req_data.req_type)
                  OP_ALLOC: begin
                     if (req_data.byte_count == '0) begin
                        emit = 1'b1;
                     end else begin
                        div_go       = 1'b1;
                        div_dividend = req_data.byte_count;
                     end
                  end
                  OP_APPEND: begin
                     if (!start_ok) begin
                        emit = 1'b1;
                        rsp_beat.status = ST_BAD_START;
                     end else if (req_data.byte_count == '0) begin
                        emit = 1'b1;
                        rsp_beat.cluster = req_data.start_cluster;
                     end
                  end
                  OP_LIST, OP_DELETE: begin
                     if (!start_ok) begin
                        emit = 1'b1;
                        rsp_beat.status = ST_BAD_START;
                     end
                  end
                  OP_SEEK: begin
                     if (!start_ok) begin
                        emit = 1'b1;
                        rsp_beat.status = ST_BAD_START;
                     end else begin
                        div_go       = 1'b1;
                        div_dividend = req_data.byte_offset;
                     end
                  end
                  OP_READ: begin
                     emit = 1'b1;
                     if (!in_range) begin
                        rsp_beat.status = ST_BAD_START;
                     end else begin
                        rsp_beat.cluster        = req_data.start_cluster;
                        rsp_beat.entry_used     = rd_used;
                        rsp_beat.entry_next_end = rd_end;
                        rsp_beat.entry_next     = rd_end ? 4'd0 : 4'(rd_link[AW-1:0]);
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (op_ff == OP_SEEK) begin
                  steps_in = div_quo;
               end else if (short) begin
                  emit = 1'b1;
                  rsp_beat.status = ST_NO_SPACE;
               end else begin
                  need_in      = CW'(need_full);
                  idx_in       = '0;
                  taken_in     = '0;
                  have_prev_in = 1'b0;
               end
            end
         end
         S_ALLOC: begin
            idx_in = idx_ff + 1'b1;
            if (!rd_used) begin
               u_we   = 1'b1;
               u_addr = idx_ff;
               u_val  = 1'b1;
               if (have_prev_ff) begin
                  n_we   = 1'b1;
                  n_addr = prev_ff;
                  n_val  = {1'b0, idx_ff};
               end else begin
                  first_in = idx_ff;
               end
               prev_in      = idx_ff;
               have_prev_in = 1'b1;
               taken_in     = taken_ff + 1'b1;
            end
         end
         S_JOIN: begin
            n_we  = 1'b1;
            n_val = {1'b0, first_ff};
         end
         S_TERM: begin
            n_we   = 1'b1;
            n_addr = prev_ff;
            emit   = 1'b1;
            rsp_beat.cluster = (op_ff == OP_ALLOC) ? 4'(first_ff) : start_ff;
         end
         S_WALK: begin
            if (rd_end) begin
               div_go = 1'b1;
            end else if (cnt_ff == CW'(NCL)) begin
               emit = 1'b1;
               rsp_beat.status = ST_BAD_START;
            end else begin
               cur_in = rd_link[AW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_LIST: begin
            emit = 1'b1;
            rsp_beat.cluster = 4'(cur_ff);
            rsp_beat.last    = list_last;
            if (!list_last) begin
               cur_in = rd_link[AW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SEEK: begin
            if (24'(cnt_ff) == steps_ff) begin
               emit = 1'b1;
               rsp_beat.cluster = 4'(cur_ff);
            end else if (cnt_ff == CW'(NCL)) begin
               anchor_in = cur_ff;
               len_in    = '0;
            end else if (rd_end) begin
               emit = 1'b1;
               rsp_beat.status = ST_PAST_END;
            end else begin
               cur_in = rd_link[AW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CYC: begin
            cur_in = rd_link[AW-1:0];
            len_in = len_ff + 1'b1;
            if (rd_link == {1'b0, anchor_ff}) begin
               div_go       = 1'b1;
               div_dividend = steps_ff - 24'(NCL);
               div_divisor  = CSIZE_BITS'(len_ff) + CSIZE_BITS'(1);
            end
         end
         S_CYCDIV: begin
            if (div_done) cnt_in = CW'(div_rem);
         end
         S_REM: begin
            if (cnt_ff == '0) begin
               emit = 1'b1;
               rsp_beat.cluster = 4'(cur_ff);
            end else begin
               cur_in = rd_link[AW-1:0];
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DEL: begin
            u_we = 1'b1;
            n_we = 1'b1;
            if (rd_end || (cnt_ff + 1'b1 == CW'(NCL))) begin
               emit = 1'b1;
               rsp_beat.cluster = start_ff;
            end else begin
               cur_in = rd_link[AW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_strobe_ff    <= 1'b0;
         cluster_bytes_ff <= CLUSTER_BYTES_RESET;
         for (int i = 0; i < NCL; i++) begin
            used_ff[i] <= 1'b0;
            next_ff[i] <= END_LINK;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= emit;
         if (csr_we) cluster_bytes_ff <= csr_wdata;
         if (u_we) used_ff[u_addr] <= u_val;
         if (n_we) next_ff[n_addr] <= n_val;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      start_ff     <= start_in;
      arg_ff       <= arg_in;
      steps_ff     <= steps_in;
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      have_prev_ff <= have_prev_in;
      taken_ff     <= taken_in;
      need_ff      <= need_in;
      anchor_ff    <= anchor_in;
      len_ff       <= len_in;
      if (emit) rsp_data_ff <= rsp_beat;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[hw/rtl/cca_checker.sv]
// Port-level checks for the cluster chain allocator, bound to the top level.
`timescale 1ns / 1ps
module cca_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input cca_pkg::req_beat_type          req_data,
   input logic                           rsp_strobe,
   input cca_pkg::rsp_beat_type          rsp_data,
   input logic                           csr_we,
   input logic [cca_pkg::CSIZE_BITS-1:0] csr_wdata
);
   import cca_pkg::*;

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or strobe after reset");

   a_error_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.last && rsp_data.cluster == 4'd0))
      else $error("error beat not final or carries a cluster");

   a_list_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> rsp_strobe)
      else $error("chain list beats not consecutive");

   a_no_accept_mid_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("idle while a chain list is still running");

endmodule

bind cluster_chain_allocator cca_checker u_cca_checker (.*);
